@@ sv/fitba_pkg.sv @@
// ----------------------------------------------------------------------------
// fitba_pkg
// Types and constants shared by the file entry table and block allocator.
// ----------------------------------------------------------------------------
package fitba_pkg;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_CREATE = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_EXISTS    = 3'd2;
   localparam logic [2:0] ST_NO_ENTRY  = 3'd3;
   localparam logic [2:0] ST_NO_BLOCK  = 3'd4;

   localparam int ID_W    = 16;
   localparam int BLKNO_W = 9;
   localparam int ENTNO_W = 4;

   typedef struct packed {
      logic [1:0]      mode;
      logic [ID_W-1:0] file_id;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [BLKNO_W-1:0] block_number;
      logic [ENTNO_W-1:0] entry_index;
   } rsp_type;

   typedef enum logic [2:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_EVAL,
      SEQ_BSCAN,
      SEQ_DONE
   } fitba_state_type;

endpackage

@@ sv/file_inode_table_block_allocator.sv @@
// ----------------------------------------------------------------------------
// file_inode_table_block_allocator
// File entry table with free-block bitmap, served by a scanning sequencer.
//
// Request channel (req_): mode (lookup, create, delete) and a 16-bit file id.
// Response channel (rsp_): status, block number and entry index, one per
// request. A transfer happens when valid is high and stall is low.
// One request at a time: req_stall stays high from the transfer until the
// result is loaded into the output register. A request first scans all
// ENTRY_COUNT entries through one compare unit, one entry per cycle, with
// the memory read registered, then decides in an evaluation state. A create
// that needs a block then walks the bitmap one bit per cycle until the
// lowest free block. After reset a clearing pass writes the bitmap, one
// block per cycle, with req_stall high; all entries start invalid.
// The result sits in an output register: the next request is taken while a
// result waits under rsp_stall, but is not finished until that one leaves.
// ----------------------------------------------------------------------------
module file_inode_table_block_allocator #(
   parameter int ENTRY_COUNT = 16,
   parameter int BLOCK_COUNT = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fitba_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fitba_pkg::rsp_type  rsp_data
);

   localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int BW = $clog2(BLOCK_COUNT);
   localparam logic [EW-1:0] ELAST = EW'(ENTRY_COUNT - 1);
   localparam logic [BW-1:0] BLAST = BW'(BLOCK_COUNT - 1);

   fitba_pkg::fitba_state_type state_ff, state_in;

   logic [1:0]                 mode_ff, mode_in;
   logic [fitba_pkg::ID_W-1:0] id_ff, id_in;
   logic [EW-1:0]              ecnt_ff, ecnt_in;
   logic                       eiss_done_ff, eiss_done_in;
   logic                       ep_ff, ep_in;
   logic [EW-1:0]              ep_idx_ff, ep_idx_in;
   logic                       hit_ff, hit_in;
   logic [EW-1:0]              hit_idx_ff, hit_idx_in;
   logic [BW-1:0]              hit_blk_ff, hit_blk_in;
   logic                       free_ff, free_in;
   logic [EW-1:0]              free_idx_ff, free_idx_in;
   logic [BW-1:0]              bcnt_ff, bcnt_in;
   logic                       biss_done_ff, biss_done_in;
   logic                       bp_ff, bp_in;
   logic [BW-1:0]              bp_idx_ff, bp_idx_in;
   fitba_pkg::rsp_type         res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   fitba_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                       st_rd_valid;
   logic [fitba_pkg::ID_W-1:0] st_rd_id;
   logic [BW-1:0]              st_rd_blk;
   logic                       st_wr_en;
   logic                       st_inv_en;
   logic                       bm_rd_used;
   logic                       bm_wr_en;
   logic [BW-1:0]              bm_wr_addr;
   logic                       bm_wr_used;

   logic                       req_xfer;
   logic                       out_free;
   logic                       id_match;
   logic                       scan_last;
   logic                       bfound;
   logic                       bscan_end;
   logic                       del_hit;
   logic [BW-1:0]              sel_blk;
   logic [EW-1:0]              sel_idx;
   logic [BW+fitba_pkg::BLKNO_W-1:0] blk_ext;
   logic [EW+fitba_pkg::ENTNO_W-1:0] idx_ext;

   fitba_entry_store #(
      .ENTRY_COUNT(ENTRY_COUNT),
      .BLOCK_COUNT(BLOCK_COUNT)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (ecnt_ff),
      .rd_valid (st_rd_valid),
      .rd_id    (st_rd_id),
      .rd_blk   (st_rd_blk),
      .wr_en    (st_wr_en),
      .wr_addr  (free_idx_ff),
      .wr_id    (id_ff),
      .wr_blk   (bp_idx_ff),
      .inv_en   (st_inv_en),
      .inv_addr (hit_idx_ff)
   );

   fitba_block_map #(
      .BLOCK_COUNT(BLOCK_COUNT)
   ) u_map (
      .clock   (clock),
      .rd_addr (bcnt_ff),
      .rd_used (bm_rd_used),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_used (bm_wr_used)
   );

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != fitba_pkg::SEQ_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign id_match  = st_rd_valid && (st_rd_id == id_ff);
   assign scan_last = ep_ff && (ep_idx_ff == ELAST);
   assign bfound    = bp_ff && !bm_rd_used;
   assign bscan_end = bp_ff && (!bm_rd_used || (bp_idx_ff == BLAST));
   assign del_hit   = (mode_ff == fitba_pkg::MODE_DELETE) && hit_ff;

   assign sel_blk = (state_ff == fitba_pkg::SEQ_BSCAN) ? bp_idx_ff : hit_blk_ff;
   assign sel_idx = (state_ff == fitba_pkg::SEQ_BSCAN) ? free_idx_ff : hit_idx_ff;
   assign blk_ext = {{fitba_pkg::BLKNO_W{1'b0}}, sel_blk};
   assign idx_ext = {{fitba_pkg::ENTNO_W{1'b0}}, sel_idx};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fitba_pkg::SEQ_CLEAR: begin
            if (bcnt_ff == BLAST) begin
               state_in = fitba_pkg::SEQ_IDLE;
            end
         end
         fitba_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               state_in = fitba_pkg::SEQ_SCAN;
            end
         end
         fitba_pkg::SEQ_SCAN: begin
            if (scan_last) begin
               state_in = fitba_pkg::SEQ_EVAL;
            end
         end
         fitba_pkg::SEQ_EVAL: begin
            if ((mode_ff == fitba_pkg::MODE_CREATE) && !hit_ff && free_ff) begin
               state_in = fitba_pkg::SEQ_BSCAN;
            end else begin
               state_in = fitba_pkg::SEQ_DONE;
            end
         end
         fitba_pkg::SEQ_BSCAN: begin
            if (bscan_end) begin
               state_in = fitba_pkg::SEQ_DONE;
            end
         end
         fitba_pkg::SEQ_DONE: begin
            if (out_free) begin
               state_in = fitba_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = fitba_pkg::SEQ_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      mode_in      = mode_ff;
      id_in        = id_ff;
      ecnt_in      = ecnt_ff;
      eiss_done_in = eiss_done_ff;
      ep_in        = ep_ff;
      ep_idx_in    = ep_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_blk_in   = hit_blk_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      bcnt_in      = bcnt_ff;
      biss_done_in = biss_done_ff;
      bp_in        = bp_ff;
      bp_idx_in    = bp_idx_ff;
      res_in       = res_ff;
      st_wr_en     = 1'b0;
      st_inv_en    = 1'b0;
      bm_wr_en     = 1'b0;
      bm_wr_addr   = bcnt_ff;
      bm_wr_used   = 1'b0;
      case (state_ff)
         fitba_pkg::SEQ_CLEAR: begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = bcnt_ff;
            bm_wr_used = (bcnt_ff < BW'(2));
            bcnt_in    = bcnt_ff + BW'(1);
         end
         fitba_pkg::SEQ_IDLE: begin
            if (req_xfer) begin
               mode_in      = req_data.mode;
               id_in        = req_data.file_id;
               ecnt_in      = '0;
               eiss_done_in = 1'b0;
               ep_in        = 1'b0;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               bcnt_in      = '0;
               biss_done_in = 1'b0;
               bp_in        = 1'b0;
            end
         end
         fitba_pkg::SEQ_SCAN: begin
            ep_in     = !eiss_done_ff;
            ep_idx_in = ecnt_ff;
            if (!eiss_done_ff) begin
               if (ecnt_ff == ELAST) begin
                  eiss_done_in = 1'b1;
               end else begin
                  ecnt_in = ecnt_ff + EW'(1);
               end
            end
            if (ep_ff && id_match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = ep_idx_ff;
               hit_blk_in = st_rd_blk;
            end
            if (ep_ff && !st_rd_valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = ep_idx_ff;
            end
         end
         fitba_pkg::SEQ_EVAL: begin
            res_in.status       = fitba_pkg::ST_OK;
            res_in.block_number = blk_ext[fitba_pkg::BLKNO_W-1:0];
            res_in.entry_index  = idx_ext[fitba_pkg::ENTNO_W-1:0];
            if (mode_ff == fitba_pkg::MODE_CREATE) begin
               if (hit_ff || !free_ff) begin
                  res_in.status       = hit_ff ? fitba_pkg::ST_EXISTS
                                               : fitba_pkg::ST_NO_ENTRY;
                  res_in.block_number = '0;
                  res_in.entry_index  = '0;
               end
            end else if (!hit_ff) begin
               res_in.status       = fitba_pkg::ST_NOT_FOUND;
               res_in.block_number = '0;
               res_in.entry_index  = '0;
            end else if (del_hit) begin
               st_inv_en  = 1'b1;
               bm_wr_en   = 1'b1;
               bm_wr_addr = hit_blk_ff;
               bm_wr_used = 1'b0;
            end
         end
         fitba_pkg::SEQ_BSCAN: begin
            bp_in     = !biss_done_ff;
            bp_idx_in = bcnt_ff;
            if (!biss_done_ff) begin
               if (bcnt_ff == BLAST) begin
                  biss_done_in = 1'b1;
               end else begin
                  bcnt_in = bcnt_ff + BW'(1);
               end
            end
            if (bfound) begin
               st_wr_en            = 1'b1;
               bm_wr_en            = 1'b1;
               bm_wr_addr          = bp_idx_ff;
               bm_wr_used          = 1'b1;
               res_in.status       = fitba_pkg::ST_OK;
               res_in.block_number = blk_ext[fitba_pkg::BLKNO_W-1:0];
               res_in.entry_index  = idx_ext[fitba_pkg::ENTNO_W-1:0];
            end else if (bscan_end) begin
               res_in.status       = fitba_pkg::ST_NO_BLOCK;
               res_in.block_number = '0;
               res_in.entry_index  = '0;
            end
         end
         fitba_pkg::SEQ_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == fitba_pkg::SEQ_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fitba_pkg::SEQ_CLEAR;
         bcnt_ff      <= '0;
         ecnt_ff      <= '0;
         eiss_done_ff <= 1'b0;
         biss_done_ff <= 1'b0;
         ep_ff        <= 1'b0;
         bp_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bcnt_ff      <= bcnt_in;
         ecnt_ff      <= ecnt_in;
         eiss_done_ff <= eiss_done_in;
         biss_done_ff <= biss_done_in;
         ep_ff        <= ep_in;
         bp_ff        <= bp_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      id_ff       <= id_in;
      ep_idx_ff   <= ep_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_blk_ff  <= hit_blk_in;
      free_idx_ff <= free_idx_in;
      bp_idx_ff   <= bp_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/fitba_entry_store.sv @@
// ----------------------------------------------------------------------------
// fitba_entry_store
// File entry table: valid bits in flops, identifier and block in a memory
// with one registered read port and one write port.
// ----------------------------------------------------------------------------
module fitba_entry_store #(
   parameter int ENTRY_COUNT = 16,
   parameter int BLOCK_COUNT = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [((ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1)-1:0] rd_addr,
   output logic                                   rd_valid,
   output logic [fitba_pkg::ID_W-1:0]             rd_id,
   output logic [$clog2(BLOCK_COUNT)-1:0]         rd_blk,
   input  logic                                   wr_en,
   input  logic [((ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1)-1:0] wr_addr,
   input  logic [fitba_pkg::ID_W-1:0]             wr_id,
   input  logic [$clog2(BLOCK_COUNT)-1:0]         wr_blk,
   input  logic                                   inv_en,
   input  logic [((ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1)-1:0] inv_addr
);

   localparam int BW = $clog2(BLOCK_COUNT);

   logic [fitba_pkg::ID_W-1:0] id_mem  [ENTRY_COUNT];
   logic [BW-1:0]              blk_mem [ENTRY_COUNT];

   logic [ENTRY_COUNT-1:0] valid_ff;
   logic [ENTRY_COUNT-1:0] valid_in;
   logic                   rd_valid_ff;
   logic [fitba_pkg::ID_W-1:0] rd_id_ff;
   logic [BW-1:0]          rd_blk_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (inv_en) begin
         valid_in[inv_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]  <= wr_id;
         blk_mem[wr_addr] <= wr_blk;
      end
      rd_id_ff    <= id_mem[rd_addr];
      rd_blk_ff   <= blk_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_id    = rd_id_ff;
   assign rd_blk   = rd_blk_ff;

endmodule

@@ sv/fitba_block_map.sv @@
// ----------------------------------------------------------------------------
// fitba_block_map
// Free-block bitmap: one bit per data block, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module fitba_block_map #(
   parameter int BLOCK_COUNT = 512
) (
   input  logic                           clock,
   input  logic [$clog2(BLOCK_COUNT)-1:0] rd_addr,
   output logic                           rd_used,
   input  logic                           wr_en,
   input  logic [$clog2(BLOCK_COUNT)-1:0] wr_addr,
   input  logic                           wr_used
);

   logic used_mem [BLOCK_COUNT];
   logic rd_used_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem[wr_addr] <= wr_used;
      end
      rd_used_ff <= used_mem[rd_addr];
   end

   assign rd_used = rd_used_ff;

endmodule

@@ sv/fitba_checker.sv @@
// ----------------------------------------------------------------------------
// fitba_checker
// Port-level checks for the file entry table and block allocator.
// ----------------------------------------------------------------------------
module fitba_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input fitba_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input fitba_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // the block is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // the bitmap clearing pass holds off requests after reset
   a_clear_pass: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open during clearing pass");

   // failures carry zero block and entry
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != fitba_pkg::ST_OK)
      |-> (rsp_data.block_number == '0) && (rsp_data.entry_index == '0))
      else $error("failed response carries nonzero fields");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= fitba_pkg::ST_NO_BLOCK)
      else $error("response status out of range");

endmodule

bind file_inode_table_block_allocator fitba_checker u_fitba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
